/* hdl/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Request and result structs, cofactor index map, datapath widths and the
// pipeline depths of the front end and the divider lanes.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // element width and quotient bits produced by each divider lane
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned QW     = 32;
  // cofactor magnitude and determinant magnitude widths
  localparam int unsigned MAG_W  = 64;
  localparam int unsigned ADET_W = 96;
  localparam int unsigned NUM_EL = 9;

  // pipeline depths
  localparam int unsigned FRONT_LAT = 9;
  localparam int unsigned LANE_LAT  = QW + 1;
  localparam int unsigned TOT_LAT   = FRONT_LAT + LANE_LAT + 1;

  // cofactor k = a[p]*a[q] - a[r]*a[s], row-major element indexes
  localparam int unsigned COF_IDX [NUM_EL][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } req_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] b00;
    logic signed [ELEM_W-1:0] b01;
    logic signed [ELEM_W-1:0] b02;
    logic signed [ELEM_W-1:0] b10;
    logic signed [ELEM_W-1:0] b11;
    logic signed [ELEM_W-1:0] b12;
    logic signed [ELEM_W-1:0] b20;
    logic signed [ELEM_W-1:0] b21;
    logic signed [ELEM_W-1:0] b22;
    logic                     singular;
  } res_t;

  // front end result handed to the divider lanes
  typedef struct packed {
    logic [NUM_EL-1:0][MAG_W-1:0] mag;
    logic [NUM_EL-1:0]            sgn;
    logic [ADET_W-1:0]            adet;
    logic                         dneg;
    logic                         sing;
  } front_t;

  // cofactor magnitudes and signs carried down the front pipeline
  typedef struct packed {
    logic [NUM_EL-1:0][MAG_W-1:0] mag;
    logic [NUM_EL-1:0]            sgn;
  } cof_t;

endpackage

/* hdl/matrix_inverse_3x3.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: fixed-point 3x3 inverse by adjugate
// Start a request with start while busy is low; req_i carries the nine
// signed elements. busy stays low, so a new matrix can start every cycle.
// The result is on res_o for one cycle with res_valid_o high. It passes the
// cofactor and determinant pipeline, the divider lanes (one quotient bit per
// stage) and one output register. Throughput is one matrix per clock.
// The receiver cannot stall; results must be taken when the strobe is high.
// The threshold is written on the cfg channel (always ready) and must only
// change while no request is in flight. Reset clears the threshold to zero
// and drops every request in flight; no result strobe follows reset until a
// new request completes.
// Nine divider lanes run side by side, one per element, and a merge stage
// applies sign, saturation and the singular zeroing.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mi3_pkg::req_t  req_i,
  output logic           res_valid_o,
  output mi3_pkg::res_t  res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [30:0]    cfg_data_i
);

  localparam int unsigned NE = mi3_pkg::NUM_EL;
  localparam int unsigned QW = mi3_pkg::QW;
  localparam int unsigned LL = mi3_pkg::LANE_LAT;
  localparam int unsigned TL = mi3_pkg::TOT_LAT;

  logic [30:0]     thr_q;
  logic [TL-1:0]   vld_q;
  logic [LL-1:0]   sing_q;
  mi3_pkg::front_t front;
  logic [QW-1:0]   quo [NE];
  logic [NE-1:0]   ovf;
  logic [NE-1:0]   neg;
  logic [31:0]     elem [NE];
  mi3_pkg::res_t   res_d;
  mi3_pkg::res_t   res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // request tracking down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TL-2:0], start & ~busy};
    end
  end

  mi3_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .mat_i   (req_i),
    .thr_i   (thr_q),
    .front_o (front)
  );

  // singular flag waits out the divider lanes
  always_ff @(posedge clk_i) begin
    sing_q <= {sing_q[LL-2:0], front.sing};
  end

  // divider lanes, one per element
  for (genvar k = 0; k < NE; k++) begin : g_lane
    mi3_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .mag_i  (front.mag[k]),
      .adet_i (front.adet),
      .neg_i  (front.sgn[k] ^ front.dneg),
      .quo_o  (quo[k]),
      .ovf_o  (ovf[k]),
      .neg_o  (neg[k])
    );
  end

  // merge: saturate, apply sign, zero on singular
  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    for (int k = 0; k < NE; k++) begin
      lim     = neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag     = (ovf[k] || quo[k] > lim) ? lim : quo[k];
      elem[k] = sing_q[LL-1] ? 32'd0 : (neg[k] ? 32'(32'd0 - mag) : mag);
    end
    res_d.b00      = elem[0];
    res_d.b01      = elem[1];
    res_d.b02      = elem[2];
    res_d.b10      = elem[3];
    res_d.b11      = elem[4];
    res_d.b12      = elem[5];
    res_d.b20      = elem[6];
    res_d.b21      = elem[7];
    res_d.b22      = elem[8];
    res_d.singular = sing_q[LL-1];
  end

  // output register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = vld_q[TL-1];

`ifndef SYNTHESIS
  // every result strobe traces back to an accepted request (start while not busy)
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start & ~busy, TL))
    else $error("result strobe without matching request");

  // a singular result carries all-zero elements
  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.singular) |->
      (res_o.b00 == 0 && res_o.b01 == 0 && res_o.b02 == 0 &&
       res_o.b10 == 0 && res_o.b11 == 0 && res_o.b12 == 0 &&
       res_o.b20 == 0 && res_o.b21 == 0 && res_o.b22 == 0))
    else $error("singular result with nonzero element");
`endif

endmodule

/* hdl/mi3_front.sv */
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Nine exact cofactors, determinant from the first row, its magnitude and the
// singular compare against the threshold. Nine stages, one matrix per cycle.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  mi3_pkg::req_t           mat_i,
  input  logic [30:0]             thr_i,
  output mi3_pkg::front_t         front_o
);

  localparam int unsigned NE = mi3_pkg::NUM_EL;
  localparam int unsigned MW = mi3_pkg::MAG_W;
  localparam int unsigned AW = mi3_pkg::ADET_W;
  localparam int unsigned CD = 6;

  logic signed [31:0] a [NE];

  logic signed [63:0] prod_q [NE][2];
  logic signed [31:0] arow1_q [3];
  logic signed [64:0] adj_q [NE];
  logic signed [31:0] arow2_q [3];
  logic [64:0]        adj_abs [NE];
  mi3_pkg::cof_t      cof3_q;
  logic [31:0]        amag_q [3];
  logic [2:0]         asg_q;
  logic [63:0]        pl_q [3];
  logic [63:0]        ph_q [3];
  logic [2:0]         tneg4_q;
  logic [95:0]        tmag_q [3];
  logic [2:0]         tneg5_q;
  logic signed [96:0] term_q [3];
  logic signed [97:0] det_q;
  logic signed [97:0] det_abs;
  logic [AW-1:0]      adet8_q;
  logic               dneg8_q;
  logic [AW-1:0]      adet9_q;
  logic               dneg9_q;
  logic               sing9_q;
  mi3_pkg::cof_t      cd_q [CD];

  // unpack the request row-major
  assign a[0] = mat_i.a00;
  assign a[1] = mat_i.a01;
  assign a[2] = mat_i.a02;
  assign a[3] = mat_i.a10;
  assign a[4] = mat_i.a11;
  assign a[5] = mat_i.a12;
  assign a[6] = mat_i.a20;
  assign a[7] = mat_i.a21;
  assign a[8] = mat_i.a22;

  // stage 1: cofactor products
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NE; k++) begin
      prod_q[k][0] <= a[mi3_pkg::COF_IDX[k][0]] * a[mi3_pkg::COF_IDX[k][1]];
      prod_q[k][1] <= a[mi3_pkg::COF_IDX[k][2]] * a[mi3_pkg::COF_IDX[k][3]];
    end
    for (int t = 0; t < 3; t++) begin
      arow1_q[t] <= a[t];
    end
  end

  // stage 2: cofactor differences
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NE; k++) begin
      adj_q[k] <= 65'(prod_q[k][0]) - 65'(prod_q[k][1]);
    end
    for (int t = 0; t < 3; t++) begin
      arow2_q[t] <= arow1_q[t];
    end
  end

  // stage 3: magnitudes and signs
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      adj_abs[k] = adj_q[k][64] ? 65'(65'sd0 - adj_q[k]) : adj_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NE; k++) begin
      cof3_q.mag[k] <= adj_abs[k][MW-1:0];
      cof3_q.sgn[k] <= adj_q[k][64];
    end
    for (int t = 0; t < 3; t++) begin
      amag_q[t] <= arow2_q[t][31] ? 32'(33'sd0 - 33'(arow2_q[t])) : 32'(arow2_q[t]);
      asg_q[t]  <= arow2_q[t][31];
    end
  end

  // stage 4: partial products of first-row terms, split on the cofactor
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 3; t++) begin
      pl_q[t]    <= 64'(amag_q[t]) * 64'(cof3_q.mag[3*t][31:0]);
      ph_q[t]    <= 64'(amag_q[t]) * 64'(cof3_q.mag[3*t][63:32]);
      tneg4_q[t] <= asg_q[t] ^ cof3_q.sgn[3*t];
    end
  end

  // stage 5: combine partial products
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 3; t++) begin
      tmag_q[t]  <= 96'(pl_q[t]) + {ph_q[t], 32'd0};
      tneg5_q[t] <= tneg4_q[t];
    end
  end

  // stage 6: signed terms
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 3; t++) begin
      term_q[t] <= tneg5_q[t] ? 97'(97'sd0 - $signed({1'b0, tmag_q[t]}))
                              : $signed({1'b0, tmag_q[t]});
    end
  end

  // stage 7: determinant
  always_ff @(posedge clk_i) begin
    det_q <= 98'(term_q[0]) + 98'(term_q[1]) + 98'(term_q[2]);
  end

  // stage 8: determinant magnitude
  assign det_abs = det_q[97] ? 98'(98'sd0 - det_q) : det_q;

  always_ff @(posedge clk_i) begin
    adet8_q <= det_abs[AW-1:0];
    dneg8_q <= det_q[97];
  end

  // stage 9: singular compare, threshold scaled to the determinant format
  always_ff @(posedge clk_i) begin
    adet9_q <= adet8_q;
    dneg9_q <= dneg8_q;
    sing9_q <= adet8_q <= (AW'(thr_i) << (2 * FRAC_BITS));
  end

  // cofactor magnitudes ride along stages 4 to 9
  always_ff @(posedge clk_i) begin
    cd_q[0] <= cof3_q;
    for (int s = 1; s < CD; s++) begin
      cd_q[s] <= cd_q[s-1];
    end
  end

  assign front_o.mag  = cd_q[CD-1].mag;
  assign front_o.sgn  = cd_q[CD-1].sgn;
  assign front_o.adet = adet9_q;
  assign front_o.dneg = dneg9_q;
  assign front_o.sing = sing9_q;

endmodule

/* hdl/mi3_lane.sv */
// ----------------------------------------------------------------------------
// mi3_lane: pipelined restoring divider for one inverse element
// Divides the scaled cofactor magnitude by the determinant magnitude, one
// quotient bit per stage, and flags quotients that exceed 32 bits.
// ----------------------------------------------------------------------------
module mi3_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [mi3_pkg::MAG_W-1:0]     mag_i,
  input  logic [mi3_pkg::ADET_W-1:0]    adet_i,
  input  logic                          neg_i,
  output logic [mi3_pkg::QW-1:0]        quo_o,
  output logic                          ovf_o,
  output logic                          neg_o
);

  localparam int unsigned QW = mi3_pkg::QW;
  localparam int unsigned AW = mi3_pkg::ADET_W;
  localparam int unsigned NW = mi3_pkg::MAG_W + 2 * FRAC_BITS;
  localparam int unsigned CW = AW + QW;

  logic [NW-1:0] num;
  logic [NW-1:0] rem_q [QW];
  logic [AW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];

  // entry stage: scale numerator, check for quotient overflow
  assign num = NW'(mag_i) << (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num;
    den_q[0] <= adet_i;
    quo_q[0] <= '0;
    neg_q[0] <= neg_i;
    ovf_q[0] <= CW'(num) >= (CW'(adet_i) << QW);
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned BIT = QW - 1 - j;
    logic [CW-1:0] sub;
    logic          ge;

    assign sub = CW'(den_q[j]) << BIT;
    assign ge  = CW'(rem_q[j]) >= sub;

    always_ff @(posedge clk_i) begin
      quo_q[j+1] <= quo_q[j] | (QW'(ge) << BIT);
      neg_q[j+1] <= neg_q[j];
      ovf_q[j+1] <= ovf_q[j];
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[j+1] <= ge ? NW'(rem_q[j] - NW'(sub)) : rem_q[j];
        den_q[j+1] <= den_q[j];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];
  assign neg_o = neg_q[QW];

endmodule
